/* rtl/cis_pkg.sv */
// Shared types and constants for the coalescing interval set.
`default_nettype none
package cis_pkg;
    localparam int CAPACITY_DEF   = 64;
    localparam int TIME_WIDTH_DEF = 64;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLIP   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_MERGE_RD,
        S_MERGE,
        S_SHIFT_RD,
        S_SHIFT,
        S_WRITE,
        S_CLIP_RD,
        S_CLIP,
        S_DONE
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;        // capture request beat
        logic rd_scan;     // read entry at scan index
        logic scan_inc;    // advance scan index
        logic merge_acc;   // fold read entry into merged interval
        logic mark_ms;     // set merge start at scan index
        logic set_shift;   // prepare shift pointers
        logic shift_wr;    // write one shifted entry
        logic shift_adv;   // advance shift pointers
        logic write_new;   // write merged entry at merge start
        logic set_count;   // commit new count
        logic clear_cnt;   // empty the set
        logic query_fin;   // capture query result
        logic out_load;    // load output register
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic [1:0] req;
        logic       empty_bad;  // start >= end
        logic       scan_end;   // index reached count
        logic       end_lt;     // read end < key (insert) / <= key (query, clip)
        logic       start_le;   // read start <= merged end
        logic       rc_zero;
        logic       full;
        logic       shift_end;
        logic       clip_bad;
        logic       clip_keep;  // read start < clip high
    } t_stat;
endpackage
`default_nettype wire

/* rtl/cis_ctrl.sv */
// Request sequencer for the coalescing interval set.
`default_nettype none
module cis_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  wire             i_stall,
    input  cis_pkg::t_stat  i_st,
    output cis_pkg::t_cmd   o_cmd
);
    cis_pkg::t_state r_state, n_state;
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cis_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) r_ovalid <= 1'b1;
            else if (!i_stall)  r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_stall = (r_state != cis_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cis_pkg::S_IDLE:
                if (i_valid) n_state = cis_pkg::S_SCAN_RD;
            cis_pkg::S_SCAN_RD: begin
                priority if (i_st.req == cis_pkg::REQ_CLEAR) n_state = cis_pkg::S_DONE;
                else if (i_st.req == cis_pkg::REQ_INSERT && i_st.empty_bad)
                    n_state = cis_pkg::S_DONE;
                else if (i_st.req == cis_pkg::REQ_CLIP && i_st.clip_bad)
                    n_state = cis_pkg::S_DONE;
                else if (i_st.scan_end) begin
                    priority if (i_st.req == cis_pkg::REQ_INSERT) n_state = cis_pkg::S_MERGE_RD;
                    else if (i_st.req == cis_pkg::REQ_QUERY) n_state = cis_pkg::S_DONE;
                    else n_state = cis_pkg::S_CLIP_RD;
                end else n_state = cis_pkg::S_SCAN;
            end
            cis_pkg::S_SCAN: begin
                if (i_st.end_lt) n_state = cis_pkg::S_SCAN_RD;
                else priority if (i_st.req == cis_pkg::REQ_INSERT)
                    n_state = cis_pkg::S_MERGE_RD;
                else if (i_st.req == cis_pkg::REQ_QUERY) n_state = cis_pkg::S_DONE;
                else n_state = cis_pkg::S_CLIP_RD;
            end
            cis_pkg::S_MERGE_RD:
                n_state = i_st.scan_end ? cis_pkg::S_SHIFT_RD : cis_pkg::S_MERGE;
            cis_pkg::S_MERGE:
                n_state = i_st.start_le ? cis_pkg::S_MERGE_RD : cis_pkg::S_SHIFT_RD;
            cis_pkg::S_SHIFT_RD: begin
                priority if (i_st.rc_zero && i_st.full) n_state = cis_pkg::S_DONE;
                else if (i_st.shift_end) n_state = cis_pkg::S_WRITE;
                else n_state = cis_pkg::S_SHIFT;
            end
            cis_pkg::S_SHIFT:
                n_state = cis_pkg::S_SHIFT_RD;
            cis_pkg::S_WRITE:
                n_state = cis_pkg::S_DONE;
            cis_pkg::S_CLIP_RD:
                n_state = i_st.shift_end ? cis_pkg::S_DONE : cis_pkg::S_CLIP;
            cis_pkg::S_CLIP:
                n_state = cis_pkg::S_CLIP_RD;
            cis_pkg::S_DONE:
                if (!r_ovalid || !i_stall) n_state = cis_pkg::S_IDLE;
            default: n_state = cis_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            cis_pkg::S_IDLE: o_cmd.load = i_valid;
            cis_pkg::S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                if (i_st.req == cis_pkg::REQ_CLEAR ||
                    (i_st.req == cis_pkg::REQ_CLIP && i_st.clip_bad))
                    o_cmd.clear_cnt = 1'b1;
                else if (i_st.scan_end) begin
                    o_cmd.mark_ms = 1'b1;
                    o_cmd.query_fin = (i_st.req == cis_pkg::REQ_QUERY);
                end
            end
            cis_pkg::S_SCAN: begin
                if (i_st.end_lt) o_cmd.scan_inc = 1'b1;
                else begin
                    o_cmd.mark_ms = 1'b1;
                    o_cmd.query_fin = (i_st.req == cis_pkg::REQ_QUERY);
                end
            end
            cis_pkg::S_MERGE_RD: begin
                o_cmd.rd_scan = 1'b1;
                o_cmd.set_shift = i_st.scan_end;
            end
            cis_pkg::S_MERGE: begin
                if (i_st.start_le) begin
                    o_cmd.merge_acc = 1'b1;
                    o_cmd.scan_inc  = 1'b1;
                end else o_cmd.set_shift = 1'b1;
            end
            cis_pkg::S_SHIFT_RD: o_cmd.rd_scan = 1'b1;
            cis_pkg::S_SHIFT: begin
                o_cmd.shift_wr  = 1'b1;
                o_cmd.shift_adv = 1'b1;
            end
            cis_pkg::S_WRITE: begin
                o_cmd.write_new = 1'b1;
                o_cmd.set_count = 1'b1;
            end
            cis_pkg::S_CLIP_RD: begin
                o_cmd.rd_scan   = 1'b1;
                o_cmd.set_count = i_st.shift_end;
            end
            cis_pkg::S_CLIP: begin
                o_cmd.shift_wr  = i_st.clip_keep;
                o_cmd.shift_adv = 1'b1;
            end
            cis_pkg::S_DONE: o_cmd.out_load = !r_ovalid || !i_stall;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/cis_dp.sv */
// Interval memory, scan pointers and compare datapath.
`default_nettype none
module cis_dp #(
    parameter int CAPACITY   = cis_pkg::CAPACITY_DEF,
    parameter int TIME_WIDTH = cis_pkg::TIME_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [1:0]             i_req_type,
    input  wire  signed [63:0]     i_start_time,
    input  wire  signed [63:0]     i_end_time,
    input  wire  signed [63:0]     i_probe_time,
    input  wire  signed [63:0]     i_clip_low,
    input  wire  signed [63:0]     i_clip_high,
    input  cis_pkg::t_cmd          i_cmd,
    output cis_pkg::t_stat         o_st,
    output logic [1:0]             o_status,
    output logic                   o_hit,
    output logic [6:0]             o_position,
    output logic [6:0]             o_entry_count
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = TIME_WIDTH;

    logic signed [TW-1:0] r_mem_s [CAPACITY];
    logic signed [TW-1:0] r_mem_e [CAPACITY];
    logic signed [TW-1:0] r_rd_s, r_rd_e;
    logic signed [TW-1:0] r_a, r_b;   // insert: merged start/end; clip: low/high
    logic signed [TW-1:0] r_probe;
    logic [1:0]  r_req;
    logic [CW-1:0] r_cnt, r_idx, r_ms, r_src, r_dst, r_ncnt;
    logic        r_hit;
    logic [CW-1:0] r_pos;
    logic [1:0]  r_status;
    logic        r_first;
    logic        r_shift_mode;
    logic        r_dir_down;   // insert with new entry: shift up, walk downward

    logic signed [TW-1:0] key;
    logic [CW-1:0] rc;
    logic        wr_en;
    logic [CW-1:0] wr_addr;
    logic signed [TW-1:0] wr_s, wr_e;

    assign key = (r_req == cis_pkg::REQ_INSERT) ? r_a :
                 (r_req == cis_pkg::REQ_QUERY) ? r_probe : r_a;
    assign rc = r_idx - r_ms;

    always_comb begin
        wr_en = 1'b0; wr_addr = r_dst; wr_s = r_rd_s; wr_e = r_rd_e;
        if (i_cmd.shift_wr) begin
            wr_en = 1'b1;
            if (r_req == cis_pkg::REQ_CLIP) begin
                if (r_first && r_rd_s < r_a) wr_s = r_a;
                if (r_rd_e > r_b) wr_e = r_b;
            end
        end else if (i_cmd.write_new) begin
            wr_en = 1'b1; wr_addr = r_ms; wr_s = r_a; wr_e = r_b;
        end
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_s[wr_addr[AW-1:0]] <= wr_s;
            r_mem_e[wr_addr[AW-1:0]] <= wr_e;
        end
        if (i_cmd.rd_scan) begin
            r_rd_s <= r_mem_s[(r_shift_mode ? r_src[AW-1:0] : r_idx[AW-1:0])];
            r_rd_e <= r_mem_e[(r_shift_mode ? r_src[AW-1:0] : r_idx[AW-1:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_shift_mode <= 1'b0;
            r_status <= cis_pkg::ST_OK;
            r_hit <= 1'b0;
            r_pos <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req   <= i_req_type;
                r_probe <= i_probe_time[TW-1:0];
                r_a     <= (i_req_type == cis_pkg::REQ_CLIP) ? i_clip_low[TW-1:0]
                                                           : i_start_time[TW-1:0];
                r_b     <= (i_req_type == cis_pkg::REQ_CLIP) ? i_clip_high[TW-1:0]
                                                           : i_end_time[TW-1:0];
                r_idx   <= '0;
                r_shift_mode <= 1'b0;
                r_status <= (i_req_type == cis_pkg::REQ_INSERT &&
                             $signed(i_start_time[TW-1:0]) >= $signed(i_end_time[TW-1:0]))
                            ? cis_pkg::ST_INVALID : cis_pkg::ST_OK;
                r_hit <= 1'b0;
                r_pos <= '0;
            end
            if (i_cmd.scan_inc) r_idx <= r_idx + 1'b1;
            if (i_cmd.mark_ms) r_ms <= r_idx;
            if (i_cmd.merge_acc) begin
                if (r_rd_s < r_a) r_a <= r_rd_s;
                if (r_rd_e > r_b) r_b <= r_rd_e;
            end
            if (i_cmd.query_fin) begin
                r_pos <= r_idx;
                r_hit <= !o_st.scan_end && (r_rd_s <= r_probe);
            end
            if (i_cmd.clear_cnt) r_cnt <= '0;
            if (i_cmd.mark_ms && r_req == cis_pkg::REQ_CLIP) begin
                // clip: source walks up from first kept entry
                r_src <= r_idx; r_dst <= '0; r_first <= 1'b1;
                r_shift_mode <= 1'b1;
            end
            if (i_cmd.set_shift) begin
                r_shift_mode <= 1'b1;
                if (rc == '0) begin
                    if (r_cnt == CW'(CAPACITY)) r_status <= cis_pkg::ST_FULL;
                    r_dir_down <= 1'b1;
                    r_src <= r_cnt - 1'b1; r_dst <= r_cnt;
                    r_ncnt <= r_cnt + 1'b1;
                end else begin
                    r_dir_down <= 1'b0;
                    r_src <= r_idx; r_dst <= r_ms + 1'b1;
                    r_ncnt <= r_cnt - (rc - 1'b1);
                end
            end
            if (i_cmd.shift_adv) begin
                if (r_req == cis_pkg::REQ_CLIP) begin
                    r_src <= r_src + 1'b1;
                    if (i_cmd.shift_wr) begin
                        r_dst <= r_dst + 1'b1; r_first <= 1'b0;
                    end
                end else if (r_dir_down) begin
                    r_src <= r_src - 1'b1; r_dst <= r_dst - 1'b1;
                end else begin
                    r_src <= r_src + 1'b1; r_dst <= r_dst + 1'b1;
                end
            end
            if (i_cmd.set_count)
                r_cnt <= (r_req == cis_pkg::REQ_CLIP) ? r_dst : r_ncnt;
        end
    end

    assign o_st.req       = r_req;
    assign o_st.empty_bad = (r_status == cis_pkg::ST_INVALID);
    assign o_st.scan_end  = (r_idx == r_cnt);
    assign o_st.end_lt    = (r_req == cis_pkg::REQ_INSERT) ? (r_rd_e < key) : (r_rd_e <= key);
    assign o_st.start_le  = (r_rd_s <= r_b);
    assign o_st.rc_zero   = (rc == '0);
    assign o_st.full      = (r_status == cis_pkg::ST_FULL);
    assign o_st.shift_end = (r_req == cis_pkg::REQ_CLIP) ? (r_src == r_cnt) :
                            r_dir_down ? (r_dst == r_ms) : (r_src == r_cnt);
    assign o_st.clip_bad  = (r_a >= r_b);
    assign o_st.clip_keep = (r_rd_s < r_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status      <= r_status;
            o_hit         <= r_hit;
            o_position    <= 7'(r_pos);
            o_entry_count <= 7'(r_cnt);
        end
    end
endmodule
`default_nettype wire

/* rtl/coalescing_interval_set.sv */
// Top level of the coalescing interval set.
//  channel | direction | beat carries
//  request | in        | req_type, start_time, end_time, probe_time, clip_low, clip_high
//  result  | out       | status, hit, position, entry_count
// One request at a time. An insert scans, merges and shifts entries, a clip scans and
// compacts the kept entries, and a query scans only up to the position it answers; a clear,
// an empty insert or an empty clip window ends without a scan. Each entry visited is read
// from memory and then compared. The result becomes valid as the next beat can be taken.
// Reset (synchronous, active low) empties the set; memory contents are not cleared.
// A stalled result holds; a new request may start, but its result waits until that clears.
`default_nettype none
module coalescing_interval_set #(
    parameter int CAPACITY   = cis_pkg::CAPACITY_DEF,
    parameter int TIME_WIDTH = cis_pkg::TIME_WIDTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [1:0]         i_req_type,
    input  wire  signed [63:0] i_start_time,
    input  wire  signed [63:0] i_end_time,
    input  wire  signed [63:0] i_probe_time,
    input  wire  signed [63:0] i_clip_low,
    input  wire  signed [63:0] i_clip_high,
    output logic               o_valid,
    input  wire                i_stall,
    output logic [1:0]         o_status,
    output logic               o_hit,
    output logic [6:0]         o_position,
    output logic [6:0]         o_entry_count
);
    cis_pkg::t_cmd  cmd;
    cis_pkg::t_stat st;

    cis_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_st(st), .o_cmd(cmd)
    );

    cis_dp #(.CAPACITY(CAPACITY), .TIME_WIDTH(TIME_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_req_type, .i_start_time, .i_end_time,
        .i_probe_time, .i_clip_low, .i_clip_high,
        .i_cmd(cmd), .o_st(st), .o_status, .o_hit, .o_position, .o_entry_count
    );
endmodule
`default_nettype wire
